// ----- rtl/core/uv_average_bar_meter_macros.svh -----
// Assertion macros for the meter's RTL.
// Each macro expects clk and rst_n in scope.
`ifndef UV_AVERAGE_BAR_METER_MACROS_SVH
`define UV_AVERAGE_BAR_METER_MACROS_SVH

// Same-cycle implication.
`define UVABM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uv_average_bar_meter: same-cycle check failed");

// Next-cycle implication.
`define UVABM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uv_average_bar_meter: next-cycle check failed");

`endif

// ----- rtl/core/uvabm_pkg.sv -----
`timescale 1ns / 1ps

package uvabm_pkg;

  localparam int WINDOW      = 20;
  localparam int BAR_COLUMNS = 32;

  localparam int SAMPLE_W = 8;
  localparam int MEAN_W   = 8;
  localparam int LEN_W    = 6;
  localparam int COLOUR_W = 2;
  localparam int SAMPLE_MAX = 255;

  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int TOTAL_W = $clog2(SAMPLE_MAX * WINDOW + 1);
  localparam int STEP_W  = (TOTAL_W > 1) ? $clog2(TOTAL_W) : 1;

  localparam logic [COLOUR_W-1:0] COLOUR_RED   = 2'd0;
  localparam logic [COLOUR_W-1:0] COLOUR_GREEN = 2'd1;
  localparam logic [COLOUR_W-1:0] COLOUR_AMBER = 2'd2;

  localparam logic [LEN_W-1:0] BAR_LEN_0 = 6'd1;
  localparam logic [LEN_W-1:0] BAR_LEN_1 = 6'd6;
  localparam logic [LEN_W-1:0] BAR_LEN_2 = 6'd12;
  localparam logic [LEN_W-1:0] BAR_LEN_3 = 6'd17;
  localparam logic [LEN_W-1:0] BAR_LEN_4 = 6'd22;
  localparam logic [LEN_W-1:0] BAR_LEN_5 = 6'd27;
  localparam logic [LEN_W-1:0] BAR_LEN_6 = 6'd32;

  localparam logic [MEAN_W-1:0] MEAN_STEP_1 = 8'd0;
  localparam logic [MEAN_W-1:0] MEAN_STEP_2 = 8'd1;
  localparam logic [MEAN_W-1:0] MEAN_STEP_3 = 8'd2;
  localparam logic [MEAN_W-1:0] MEAN_STEP_4 = 8'd5;
  localparam logic [MEAN_W-1:0] MEAN_STEP_5 = 8'd7;
  localparam logic [MEAN_W-1:0] MEAN_STEP_6 = 8'd10;

  localparam logic [LEN_W-1:0] AMBER_ABOVE = 6'd12;
  localparam logic [LEN_W-1:0] RED_ABOVE   = 6'd22;

  function automatic logic [LEN_W-1:0] bar_for_mean(input logic [MEAN_W-1:0] mean);
    logic [LEN_W-1:0] len;
    if (mean > MEAN_STEP_6) begin
      len = BAR_LEN_6;
    end else if (mean > MEAN_STEP_5) begin
      len = BAR_LEN_5;
    end else if (mean > MEAN_STEP_4) begin
      len = BAR_LEN_4;
    end else if (mean > MEAN_STEP_3) begin
      len = BAR_LEN_3;
    end else if (mean > MEAN_STEP_2) begin
      len = BAR_LEN_2;
    end else if (mean > MEAN_STEP_1) begin
      len = BAR_LEN_1;
    end else begin
      len = BAR_LEN_0;
    end
    return len;
  endfunction

  function automatic logic [COLOUR_W-1:0] colour_for_bar(input logic [LEN_W-1:0] len);
    logic [COLOUR_W-1:0] colour;
    if (len > RED_ABOVE) begin
      colour = COLOUR_RED;
    end else if (len > AMBER_ABOVE) begin
      colour = COLOUR_AMBER;
    end else begin
      colour = COLOUR_GREEN;
    end
    return colour;
  endfunction

  function automatic logic [BAR_COLUMNS-1:0] mask_for_bar(input logic [LEN_W-1:0] len);
    logic [BAR_COLUMNS-1:0] mask;
    for (int i = 0; i < BAR_COLUMNS; i++) begin
      mask[i] = (LEN_W'(i) < len);
    end
    return mask;
  endfunction

endpackage

// ----- rtl/core/uvabm_ram.sv -----
`timescale 1ns / 1ps

module uvabm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/uv_average_bar_meter.sv -----
`timescale 1ns / 1ps
// UV average bar meter. Each input transaction carries one UV index sample and a
// read-error flag. A good sample enters a ring of the last 20 samples and the block
// returns the truncated mean of the held samples, the bar length from the threshold
// ladder, a bar mask with that many low bits set, and the bar colour. A failed read
// leaves the ring alone and returns an empty green bar with a zero mean. The input
// is ready only while the sequencer is idle. A good sample passes from acceptance
// to the result register in order: the ring is read at acceptance, the update state
// updates the running total, the restoring divider produces one quotient bit per
// cycle, and the done state maps the mean onto the bar. A failed read skips the update
// and the divider. The result register holds one finished result, so the next sample is
// processed while a result waits to be taken. The ring needs no clearing after reset.

`include "uv_average_bar_meter_macros.svh"

module uv_average_bar_meter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] uv_index
  input  logic [0:0]  in_tuser,   // [0] read_error
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [7:0] mean_index, [13:8] bar_length,
                                  // [45:14] bar_mask, [47:46] bar_colour
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UPDATE = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_DONE   = 3'd3;

  logic [2:0]                      state_r, state_nxt;
  logic [uvabm_pkg::SLOT_W-1:0]    slot_r, slot_nxt;
  logic                            full_r, full_nxt;
  logic [uvabm_pkg::TOTAL_W-1:0]   total_r, total_nxt;
  logic [uvabm_pkg::SAMPLE_W-1:0]  sample_r, sample_nxt;
  logic                            err_r, err_nxt;
  logic [uvabm_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [uvabm_pkg::TOTAL_W-1:0]   quo_r, quo_nxt;
  logic [uvabm_pkg::CNT_W-1:0]     rem_r, rem_nxt;
  logic [uvabm_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [47:0]                     out_data_r, out_data_nxt;

  logic                            in_accept;
  logic                            ram_wr_en;
  logic [uvabm_pkg::SAMPLE_W-1:0]  ram_rd_data;
  logic [uvabm_pkg::SAMPLE_W-1:0]  old_sample;
  logic [uvabm_pkg::CNT_W:0]       rem_shift;
  logic                            load_out;
  logic [uvabm_pkg::MEAN_W-1:0]    mean;
  logic [uvabm_pkg::LEN_W-1:0]     bar_len;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign ram_wr_en  = (state_r == ST_UPDATE);
  assign old_sample = full_r ? ram_rd_data : '0;
  assign rem_shift  = {rem_r, quo_r[uvabm_pkg::TOTAL_W-1]};
  assign load_out   = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign mean       = quo_r[uvabm_pkg::MEAN_W-1:0];
  assign bar_len    = uvabm_pkg::bar_for_mean(mean);

  uvabm_ram #(
    .WIDTH(uvabm_pkg::SAMPLE_W),
    .DEPTH(uvabm_pkg::WINDOW)
  ) u_ring (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(slot_r),
    .wr_data(sample_r),
    .rd_en  (in_accept),
    .rd_addr(slot_r),
    .rd_data(ram_rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    full_nxt      = full_r;
    total_nxt     = total_r;
    sample_nxt    = sample_r;
    err_nxt       = err_r;
    count_nxt     = count_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          sample_nxt = in_tdata;
          err_nxt    = in_tuser[0];
          state_nxt  = in_tuser[0] ? ST_DONE : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        total_nxt = total_r - uvabm_pkg::TOTAL_W'(old_sample)
                  + uvabm_pkg::TOTAL_W'(sample_r);
        if (slot_r == uvabm_pkg::SLOT_W'(uvabm_pkg::WINDOW - 1)) begin
          slot_nxt  = '0;
          full_nxt  = 1'b1;
          count_nxt = uvabm_pkg::CNT_W'(uvabm_pkg::WINDOW);
        end else begin
          slot_nxt  = slot_r + 1'b1;
          count_nxt = full_r ? uvabm_pkg::CNT_W'(uvabm_pkg::WINDOW)
                             : uvabm_pkg::CNT_W'(slot_r) + 1'b1;
        end
        quo_nxt   = total_nxt;
        rem_nxt   = '0;
        step_nxt  = uvabm_pkg::STEP_W'(uvabm_pkg::TOTAL_W - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (rem_shift >= {1'b0, count_r}) begin
          rem_nxt = uvabm_pkg::CNT_W'(rem_shift - {1'b0, count_r});
          quo_nxt = {quo_r[uvabm_pkg::TOTAL_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_shift[uvabm_pkg::CNT_W-1:0];
          quo_nxt = {quo_r[uvabm_pkg::TOTAL_W-2:0], 1'b0};
        end
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          if (err_r) begin
            out_data_nxt = {uvabm_pkg::COLOUR_GREEN, 32'd0, 6'd0, 8'd0};
          end else begin
            out_data_nxt = {uvabm_pkg::colour_for_bar(bar_len),
                            uvabm_pkg::mask_for_bar(bar_len), bar_len, mean};
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      full_r      <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      full_r      <= full_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    err_r      <= err_nxt;
    count_r    <= count_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

  `UVABM_ASSERT_NXT(a_err_skips_divide, in_accept && in_tuser[0], state_r == ST_DONE)
  `UVABM_ASSERT_IMP(a_div_count_nonzero, state_r == ST_DIV, count_r != '0)
  `UVABM_ASSERT_IMP(a_slot_in_ring, 1'b1,
                    slot_r <= uvabm_pkg::SLOT_W'(uvabm_pkg::WINDOW - 1))
  `UVABM_ASSERT_IMP(a_empty_bar_only_on_error, out_valid_r && (out_tdata[13:8] == 6'd0),
                    (out_tdata[7:0] == 8'd0) && (out_tdata[45:14] == 32'd0))

endmodule

// ----- tb/sv/uv_meter_checker.sv -----
`timescale 1ns / 1ps

module uv_meter_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] uv_index
  input  logic [0:0]  in_tuser,   // [0] read_error
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // [7:0] mean_index, [13:8] bar_length,
                                  // [45:14] bar_mask, [47:46] bar_colour
  output int          mismatch_count,
  output int          readings_owed
);

  typedef struct packed {
    logic [uvabm_pkg::COLOUR_W-1:0]    colour;
    logic [uvabm_pkg::BAR_COLUMNS-1:0] mask;
    logic [uvabm_pkg::LEN_W-1:0]       len;
    logic [uvabm_pkg::MEAN_W-1:0]      mean;
  } reading_t;

  reading_t pending_readings[$];

  logic [uvabm_pkg::SAMPLE_W-1:0] held_samples [uvabm_pkg::WINDOW];
  logic [uvabm_pkg::SLOT_W-1:0]   next_slot;
  logic                           wrapped;
  logic [uvabm_pkg::TOTAL_W-1:0]  sample_sum;

  function automatic logic [uvabm_pkg::LEN_W-1:0] ladder_length(input int unsigned m);
    logic [uvabm_pkg::LEN_W-1:0] len;
    if (m > 10) begin
      len = 6'd32;
    end else if (m > 7) begin
      len = 6'd27;
    end else if (m > 5) begin
      len = 6'd22;
    end else if (m > 2) begin
      len = 6'd17;
    end else if (m > 1) begin
      len = 6'd12;
    end else if (m > 0) begin
      len = 6'd6;
    end else begin
      len = 6'd1;
    end
    return len;
  endfunction

  // Returns the reading for one input; a good input also advances the sample window.
  function automatic reading_t next_reading(input logic [uvabm_pkg::SAMPLE_W-1:0] uv,
                                            input logic err);
    reading_t r;
    int unsigned count;
    int unsigned m;
    logic [uvabm_pkg::BAR_COLUMNS:0] wide;
    if (err) begin
      r.mean   = '0;
      r.len    = '0;
      r.mask   = '0;
      r.colour = uvabm_pkg::COLOUR_GREEN;
      return r;
    end
    if (wrapped) begin
      sample_sum = sample_sum - held_samples[next_slot];
    end
    held_samples[next_slot] = uv;
    sample_sum = sample_sum + uv;
    if (next_slot == uvabm_pkg::SLOT_W'(uvabm_pkg::WINDOW - 1)) begin
      next_slot = '0;
      wrapped   = 1'b1;
    end else begin
      next_slot = next_slot + 1'b1;
    end
    count  = wrapped ? uvabm_pkg::WINDOW : next_slot;
    m      = (count != 0) ? (sample_sum / count) : 0;
    r.mean = m[uvabm_pkg::MEAN_W-1:0];
    r.len  = ladder_length(r.mean);
    wide   = (33'd1 << r.len) - 33'd1;
    r.mask = wide[uvabm_pkg::BAR_COLUMNS-1:0];
    if (r.len > 6'd22) begin
      r.colour = uvabm_pkg::COLOUR_RED;
    end else if (r.len > 6'd12) begin
      r.colour = uvabm_pkg::COLOUR_AMBER;
    end else begin
      r.colour = uvabm_pkg::COLOUR_GREEN;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (!rst_n) begin
      pending_readings.delete();
      next_slot      = '0;
      wrapped        = 1'b0;
      sample_sum     = '0;
      mismatch_count <= 0;
      readings_owed  <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        pending_readings.push_back(next_reading(in_tdata, in_tuser[0]));
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_readings.size() == 0) begin
          $display("%0t: expected no transaction, got %h", $time, got);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = pending_readings.pop_front();
          if (got.mean !== want.mean || got.len !== want.len ||
              got.mask !== want.mask || got.colour !== want.colour) begin
            $display("%0t: expected %h, got %h", $time, want, got);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      readings_owed <= pending_readings.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int SAMPLE_COUNT = 1600;
  localparam int DRAIN_CYCLES = 24;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] uv_index
  logic [0:0]  in_tuser = '0;   // [0] read_error
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // [7:0] mean_index, [13:8] bar_length,
                                // [45:14] bar_mask, [47:46] bar_colour
  int          mismatch_count;
  int          readings_owed;
  logic        steady_in = 1'b0;
  logic        steady_out = 1'b0;

  always begin
    #4;
    clk = 1'b1;
    #4;
    clk = 1'b0;
  end

  uv_average_bar_meter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  uv_meter_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .readings_owed  (readings_owed)
  );

  task automatic send_sample(input logic [7:0] uv, input logic err);
    int gap;
    gap = steady_in ? 0 : $urandom_range(15);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= uv;
    in_tuser[0] <= err;
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    int served;
    int stall;
    served = 0;
    forever begin
      if (served % 32 == 0) begin
        steady_out <= ($urandom_range(3) == 0);
        @(posedge clk);
      end
      stall = steady_out ? 0 : $urandom_range(15);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && rst_n));
      served++;
    end
  end

  initial begin
    int sent;
    int burst_len;
    int mode;
    int err_pct;
    int lo;
    int hi;
    logic [7:0] uv;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The opening items walk every bar length before the window fills.
    send_sample(8'd255, 1'b1);
    send_sample(8'd0,   1'b0);
    send_sample(8'd1,   1'b0);
    send_sample(8'd3,   1'b0);
    send_sample(8'd4,   1'b0);
    send_sample(8'd7,   1'b0);
    send_sample(8'd21,  1'b0);
    send_sample(8'd20,  1'b0);
    send_sample(8'd32,  1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd0,   1'b1);
    for (int i = 0; i < 12; i++) begin
      send_sample((i % 2 == 0) ? 8'd255 : 8'd170, 1'b0);
    end

    sent = 23;
    while (sent < SAMPLE_COUNT) begin
      burst_len = $urandom_range(20, 60);
      mode      = $urandom_range(3);
      case ($urandom_range(3))
        0:       err_pct = 0;
        1:       err_pct = 50;
        default: err_pct = 12;
      endcase
      steady_in <= ($urandom_range(3) == 0);
      case (mode)
        0:       begin lo = 0; hi = 15; end
        1:       begin lo = 0; hi = 40; end
        default: begin lo = 0; hi = 255; end
      endcase
      for (int i = 0; i < burst_len; i++) begin
        if (mode == 3) begin
          uv = ($urandom_range(1) == 0) ? 8'd0 : 8'd255;
        end else begin
          uv = 8'($urandom_range(hi, lo));
        end
        send_sample(uv, $urandom_range(99) < err_pct);
        sent++;
      end
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (readings_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
